/* rtl/kest_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kest_pkg: shared types and helpers for the key edge state table
// Command codes, controller states, payload structs and the entry update rule.
// ----------------------------------------------------------------------------
package kest_pkg;

	localparam int KEYS_DEFAULT = 256;
	localparam int ENTRY_W      = 3;
	localparam int CELL_W       = 15;
	localparam int CODE_W       = 16;

	// entry layout
	localparam logic [ENTRY_W-1:0] BIT_HELD     = 3'b001;
	localparam logic [ENTRY_W-1:0] BIT_PRESSED  = 3'b010;
	localparam logic [ENTRY_W-1:0] BIT_RELEASED = 3'b100;

	typedef enum logic [2:0] {
		CMD_KEY   = 3'd0,
		CMD_MOUSE = 3'd1,
		CMD_FOCUS = 3'd2,
		CMD_FRAME = 3'd3,
		CMD_QUERY = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [CODE_W-1:0] key_code;
		logic              key_down;
		logic [2:0]        button_mask;
		logic [CELL_W-1:0] cell_col;
		logic [CELL_W-1:0] cell_row;
	} request_t;

	typedef struct packed {
		logic              held;
		logic              pressed_flag;
		logic              released_flag;
		logic              activity;
		logic [CELL_W-1:0] cursor_col;
		logic [CELL_W-1:0] cursor_row;
	} result_t;

	// Record a transition only when the level really changes.
	function automatic logic [ENTRY_W-1:0] apply_level(input logic [ENTRY_W-1:0] e,
			input logic down);
		logic [ENTRY_W-1:0] r;
		r = e;
		if (e[0] != down) begin
			if (down) begin
				r = e | BIT_PRESSED | BIT_HELD;
			end else begin
				r = (e | BIT_RELEASED) & ~BIT_HELD;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/kest_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kest_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kest_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/key_edge_state_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_edge_state_table: per-key held / pressed / released table
// Read-modify-write controller around one table RAM, plus the cursor cell.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low. The request
//   struct carries the command and its operands. Only a query returns a
//   result: done pulses for one cycle with the result struct valid, and the
//   receiver must take it in that cycle.
// Sequence per command:
//   key event     read, write back
//   mouse event   three button keys, reads overlapped with writes
//   focus lost, frame end: sweep over every entry, one entry per cycle
//   query         read; done is asserted in the last busy cycle
//   Commands 5..7 and key events beyond the table leave busy low.
//   A new command is not taken until the last one is through and busy is low.
// Reset:
//   After arst_n releases, a clearing pass writes zero to every entry, one
//   per cycle; busy is high meanwhile. The cursor resets to zero.
// ----------------------------------------------------------------------------
module key_edge_state_table #(
	parameter int KEYS = kest_pkg::KEYS_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire kest_pkg::request_t request,
	output      logic              done,
	output      kest_pkg::result_t result
);

	import kest_pkg::*;

	localparam int AW = $clog2(KEYS);
	localparam int CW = $clog2(KEYS + 1);
	localparam logic [CODE_W:0] KEYS_L   = (CODE_W+1)'(KEYS);
	localparam logic [CW-1:0]   LAST_IDX = CW'(KEYS - 1);
	localparam logic [CW-1:0]   N_ALL    = CW'(KEYS);

	state_t state_q, state_d;

	logic [2:0]        op_q;
	logic [AW-1:0]     code_q;
	logic              oor_q;
	logic              down_q;
	logic [2:0]        mask_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     n_q;
	logic [CELL_W-1:0] cursor_col_q;
	logic [CELL_W-1:0] cursor_row_q;

	logic              valid_s1;
	logic [AW-1:0]     addr_s1;
	logic              level_s1;

	logic              accept;
	logic              in_range;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              rd_level;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [ENTRY_W-1:0] q_entry;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = ({1'b0, request.key_code} < KEYS_L);

	// read side: pick the target of the current step
	always_comb begin
		rd_en    = (state_q == ST_RUN) && (idx_q < n_q);
		rd_addr  = code_q;
		rd_level = down_q;
		case (op_q)
			CMD_MOUSE: begin
				rd_level = mask_q[idx_q[1:0]];
				case (idx_q[1:0])
					2'd0:    rd_addr = AW'(1);
					2'd1:    rd_addr = AW'(2);
					default: rd_addr = AW'(4);
				endcase
			end
			CMD_FOCUS: begin
				rd_addr  = idx_q[AW-1:0];
				rd_level = 1'b0;
			end
			CMD_FRAME: begin
				rd_addr = idx_q[AW-1:0];
			end
			default: begin
				rd_addr  = code_q;
				rd_level = down_q;
			end
		endcase
	end

	// write side: clearing pass, or write back the entry read last cycle (queries write nothing)
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = apply_level(rdata, level_s1);
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
			wdata = '0;
		end else if (valid_s1 && (op_q != CMD_QUERY)) begin
			we = 1'b1;
			if (op_q == CMD_FRAME) begin
				wdata = rdata & BIT_HELD;
			end
		end
	end

	kest_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(KEYS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (request.command)
						CMD_KEY:   state_d = in_range ? ST_RUN : ST_IDLE;
						CMD_MOUSE, CMD_FOCUS, CMD_FRAME, CMD_QUERY: state_d = ST_RUN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN: begin
				if (!rd_en && !valid_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			n_q          <= '0;
			valid_s1     <= 1'b0;
			done         <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			done     <= valid_s1 && (op_q == CMD_QUERY);
			if (accept) begin
				idx_q <= '0;
				case (request.command)
					CMD_MOUSE: begin
						n_q          <= CW'(3);
						cursor_col_q <= request.cell_col;
						cursor_row_q <= request.cell_row;
					end
					CMD_FOCUS, CMD_FRAME: n_q <= N_ALL;
					default:   n_q <= CW'(1);
				endcase
			end else if (rd_en || (state_q == ST_CLEAR)) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// operands and pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= request.command;
			code_q <= request.key_code[AW-1:0];
			oor_q  <= !in_range;
			down_q <= request.key_down;
			mask_q <= request.button_mask;
		end
		addr_s1  <= rd_addr;
		level_s1 <= rd_level;
	end

	// query result; codes beyond the table read as an empty entry
	assign q_entry = oor_q ? '0 : rdata;

	always_ff @(posedge clk) begin
		if (valid_s1 && (op_q == CMD_QUERY)) begin
			result.held          <= q_entry[0];
			result.pressed_flag  <= q_entry[1];
			result.released_flag <= q_entry[2];
			result.activity      <= |q_entry;
			result.cursor_col    <= cursor_col_q;
			result.cursor_row    <= cursor_row_q;
		end
	end

	// a result only follows a query lookup
	a_done_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(valid_s1) && ($past(op_q) == CMD_QUERY)))
		else $error("done without a query lookup");

	// overlapped read and write back never hit the same entry
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && rd_en) |-> (waddr != rd_addr))
		else $error("read and write to the same entry");

	// nothing is in flight once the controller is idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !valid_s1)
		else $error("lookup in flight while idle");

	// step counter never runs past the step count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= n_q))
		else $error("step counter overrun");

	// the clearing pass holds the block off
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (busy && !rd_en))
		else $error("activity during clearing pass");

endmodule
`default_nettype wire

/* sim/key_edge_state_table_tb.sv */
// ----------------------------------------------------------------------------
// key_edge_state_table_tb: regression bench for the key edge state table
// Sends key, mouse, focus-lost, frame-end, query and unused commands, keeps its own
// copy of the per-key table and cursor cell, and checks each query result.
// ----------------------------------------------------------------------------
module key_edge_state_table_tb;
	import kest_pkg::*;

	localparam int KEYS = KEYS_DEFAULT;
	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT = 4 * KEYS + 64;

	// command codes the block ignores
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	// key codes driven by the mouse buttons
	localparam int MOUSE_LEFT_KEY   = 1;
	localparam int MOUSE_RIGHT_KEY  = 2;
	localparam int MOUSE_MIDDLE_KEY = 4;

	localparam logic [CELL_W-1:0] CELL_MAX = '1;
	localparam logic [CODE_W-1:0] CODE_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;

	logic [ENTRY_W-1:0] key_entries [KEYS];
	logic [CELL_W-1:0] cursor_col_q = '0;
	logic [CELL_W-1:0] cursor_row_q = '0;

	result_t expected_reports[$];
	int mismatch_count = 0;
	int stall_cycles = 0;
	int burst_left = 0;

	key_edge_state_table #(.KEYS(KEYS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---- key state tracking ------------------------------------------------

	function automatic void drive_key_level(int code, logic down);
		logic [ENTRY_W-1:0] e;
		if (code >= KEYS) return;
		e = key_entries[code];
		if (e[0] == down) return;
		if (down) e = e | BIT_HELD | BIT_PRESSED;
		else e = (e & ~BIT_HELD) | BIT_RELEASED;
		key_entries[code] = e;
	endfunction

	function automatic void track_key_command(request_t r);
		logic [ENTRY_W-1:0] e;
		result_t rep;
		case (r.command)
			CMD_KEY: drive_key_level(int'(r.key_code), r.key_down);
			CMD_MOUSE: begin
				cursor_col_q = r.cell_col;
				cursor_row_q = r.cell_row;
				drive_key_level(MOUSE_LEFT_KEY, r.button_mask[0]);
				drive_key_level(MOUSE_RIGHT_KEY, r.button_mask[1]);
				drive_key_level(MOUSE_MIDDLE_KEY, r.button_mask[2]);
			end
			CMD_FOCUS: begin
				for (int i = 0; i < KEYS; i++) drive_key_level(i, 1'b0);
			end
			CMD_FRAME: begin
				for (int i = 0; i < KEYS; i++) key_entries[i] = key_entries[i] & BIT_HELD;
			end
			CMD_QUERY: begin
				e = (int'(r.key_code) < KEYS) ? key_entries[r.key_code] : '0;
				rep.held = e[0];
				rep.pressed_flag = e[1];
				rep.released_flag = e[2];
				rep.activity = |e;
				rep.cursor_col = cursor_col_q;
				rep.cursor_row = cursor_row_q;
				expected_reports.push_back(rep);
			end
			default: ;
		endcase
	endfunction

	// ---- result checking ---------------------------------------------------

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t exp;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$error("result with no query outstanding");
				mismatch_count++;
			end else begin
				exp = expected_reports.pop_front();
				check_field("held", 32'(exp.held), 32'(result.held));
				check_field("pressed_flag", 32'(exp.pressed_flag),
					32'(result.pressed_flag));
				check_field("released_flag", 32'(exp.released_flag),
					32'(result.released_flag));
				check_field("activity", 32'(exp.activity), 32'(result.activity));
				check_field("cursor_col", 32'(exp.cursor_col), 32'(result.cursor_col));
				check_field("cursor_row", 32'(exp.cursor_row), 32'(result.cursor_row));
			end
		end
	end

	// watchdog: cycles without any transfer in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("key_edge_state_table regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ---- sender ------------------------------------------------------------

	// Called at a falling edge; returns at a falling edge with start still high.
	task automatic send_request(request_t r);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		track_key_command(r);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		start <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		pause_sender();
		while (expected_reports.size() != 0) @(negedge clk);
	endtask

	function automatic request_t make_request(logic [2:0] cmd, int code, logic down = 1'b0,
			logic [2:0] mask = '0, logic [CELL_W-1:0] col = '0,
			logic [CELL_W-1:0] row = '0);
		request_t r;
		r.command = cmd;
		r.key_code = CODE_W'(code);
		r.key_down = down;
		r.button_mask = mask;
		r.cell_col = col;
		r.cell_row = row;
		return r;
	endfunction

	// ---- directed tests ----------------------------------------------------

	task automatic test_key_transitions();
		send_request(make_request(CMD_KEY, 0, 1'b1));
		send_request(make_request(CMD_KEY, 0, 1'b1));  // same level: no change
		send_request(make_request(CMD_QUERY, 0));
		send_request(make_request(CMD_KEY, 0, 1'b0));
		send_request(make_request(CMD_QUERY, 0));      // both flags set in one frame
		send_request(make_request(CMD_KEY, KEYS - 1, 1'b1));
		send_request(make_request(CMD_QUERY, KEYS - 1));
	endtask

	task automatic test_frame_end();
		send_request(make_request(CMD_FRAME, 0));
		send_request(make_request(CMD_QUERY, 0));
		send_request(make_request(CMD_QUERY, KEYS - 1));
	endtask

	task automatic test_mouse();
		send_request(make_request(CMD_MOUSE, 0, 1'b0, 3'b111, CELL_MAX, CELL_MAX));
		send_request(make_request(CMD_QUERY, MOUSE_MIDDLE_KEY));
		send_request(make_request(CMD_MOUSE, 0, 1'b0, 3'b000, '0, '0));
		send_request(make_request(CMD_QUERY, MOUSE_LEFT_KEY));
	endtask

	task automatic test_focus_lost();
		send_request(make_request(CMD_KEY, 3, 1'b1));
		send_request(make_request(CMD_FOCUS, 0));
		send_request(make_request(CMD_QUERY, 3));
		send_request(make_request(CMD_QUERY, KEYS - 1));
	endtask

	task automatic test_codes_beyond_table();
		send_request(make_request(CMD_KEY, CODE_MAX, 1'b1));
		send_request(make_request(CMD_KEY, KEYS, 1'b1));
		send_request(make_request(CMD_QUERY, CODE_MAX));
		send_request(make_request(CMD_QUERY, KEYS));
	endtask

	task automatic test_unused_commands();
		request_t r;
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
			r = request_t'(($bits(request_t))'({$urandom, $urandom}));
			r.command = 3'(c);
			send_request(r);
		end
	endtask

	// ---- random traffic ----------------------------------------------------

	// Mostly a handful of keys so presses, queries and releases meet.
	function automatic logic [CODE_W-1:0] pick_key_code();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75) return CODE_W'($urandom_range(0, 15));
		if (p < 93) return CODE_W'($urandom_range(0, KEYS - 1));
		return CODE_W'($urandom);
	endfunction

	function automatic request_t random_request();
		request_t r;
		int p;
		r = request_t'(($bits(request_t))'({$urandom, $urandom}));
		p = $urandom_range(0, 999);
		if (p < 400) begin
			r.command = CMD_KEY;
			r.key_code = pick_key_code();
		end else if (p < 530) begin
			r.command = CMD_MOUSE;
		end else if (p < 550) begin
			r.command = CMD_FOCUS;
		end else if (p < 580) begin
			r.command = CMD_FRAME;
		end else if (p < 970) begin
			r.command = CMD_QUERY;
			r.key_code = pick_key_code();
		end else begin
			r.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		end
		return r;
	endfunction

	task automatic test_random_traffic();
		request_t r;
		int counted;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = random_request();
			send_request(r);
			if (!(r.command > CMD_QUERY || (r.command == CMD_KEY && int'(r.key_code) >= KEYS)))
				counted++;
			// let the block drain completely whenever the count stands at midway
			if (counted == RANDOM_ITEMS / 2) wait_all_results();
		end
	endtask

	initial begin
		for (int i = 0; i < KEYS; i++) key_entries[i] = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_key_transitions();
		test_frame_end();
		test_mouse();
		test_focus_lost();
		test_codes_beyond_table();
		test_unused_commands();
		test_random_traffic();

		wait_all_results();
		repeat (KEYS + 16) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("key_edge_state_table regression: pass");
		end else begin
			$display("key_edge_state_table regression: fail");
		end
		$finish;
	end

endmodule
